// ===== rtl/lnb_pkg.sv =====
`timescale 1ns / 1ps
package lnb_pkg;

  // body count and fixed-point format of the stored state
  localparam int BODY_COUNT    = 3;
  localparam int FRACTION_BITS = 24;
  localparam int IDX_W         = $clog2(BODY_COUNT);

  // shared unit runs a fixed number of iterations per operation
  localparam int ITER_COUNT = 64;
  localparam int CNT_W      = $clog2(ITER_COUNT);

  // width of accelerations and of value updates before clamping
  localparam int ACC_W = 40;

  localparam logic [ACC_W-1:0]        PAIR_LIMIT = ACC_W'(64'd1 << 35);
  localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN    = ACC_W'(-64'sd2147483648);

  typedef enum logic [1:0] {
    OPC_LOAD = 2'd0,
    OPC_RUN  = 2'd1,
    OPC_READ = 2'd2,
    OPC_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_TIME_STEP    = 2'd0,
    CFG_GRAVITY_GAIN = 2'd1,
    CFG_SOFTENING    = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ARITH_MUL  = 2'd0,
    ARITH_DIV  = 2'd1,
    ARITH_SQRT = 2'd2
  } arith_op_t;

  typedef logic [IDX_W-1:0] body_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } body_rec_t;

  typedef struct packed {
    logic      we;
    body_idx_t waddr;
    body_rec_t wdata;
    body_idx_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic        start;
    arith_op_t   op;
    logic [63:0] a;
    logic [63:0] b;
  } arith_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] result;
  } arith_rsp_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } sat_res_t;

  // magnitude of a 32-bit signed value
  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // magnitude of an acceleration
  function automatic logic [ACC_W-1:0] mag_acc(logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
  endfunction

  // give a magnitude the requested sign
  function automatic logic signed [ACC_W-1:0] apply_sign(logic neg, logic [ACC_W-1:0] m);
    return neg ? $signed(~m + ACC_W'(1)) : $signed(m);
  endfunction

  // add and clamp to the signed 32-bit range
  function automatic sat_res_t sat_add(logic signed [31:0] v, logic signed [ACC_W-1:0] d);
    logic signed [ACC_W-1:0] s;
    sat_res_t r;
    s = $signed({{(ACC_W-32){v[31]}}, v}) + d;
    r.sat = 1'b0;
    r.value = s[31:0];
    if (s > SAT_MAX) begin
      r.value = SAT_MAX[31:0];
      r.sat = 1'b1;
    end else if (s < SAT_MIN) begin
      r.value = SAT_MIN[31:0];
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/leapfrog_nbody_gravity_step_unit.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       command item: opcode, body, state, step count
// m_*       out  m_tvalid / m_tready       one report item per body, tlast on the final body
// cfg_*     in   cfg_we                    time step, gravity gain, softening square
//
// load and unused-opcode items are taken while idle; a read item reports each body in turn
// a run item performs its leapfrog steps for three bodies, then the report
// each operation goes through the one shared 64-iteration multiply/divide/sqrt unit;
// a half kick works each body pair out once from each side, eight operations each time,
// and a pair with zero distance term skips the last six of them
// reset is synchronous; stored bodies then read as zero, flags and configuration registers take their defaults
// no item is taken while a run or report is under way; a stalled report item holds
module leapfrog_nbody_gravity_step_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // body_index, load_pos_x, load_pos_y, load_vel_x, load_vel_y, step_count
  input  logic [143:0] s_tdata,
  // opcode
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_body, out_pos_x, out_pos_y, out_vel_x, out_vel_y
  output logic [135:0] m_tdata,
  // saturated
  output logic [0:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [30:0]  cfg_data
);
  import lnb_pkg::*;

  typedef enum logic [23:0] {
    ST_IDLE  = 24'h000001,
    ST_KRD   = 24'h000002,
    ST_KLAT  = 24'h000004,
    ST_PRD   = 24'h000008,
    ST_PLAT  = 24'h000010,
    ST_MXX   = 24'h000020,
    ST_MYY   = 24'h000040,
    ST_SQRT  = 24'h000080,
    ST_TDIV  = 24'h000100,
    ST_UX    = 24'h000200,
    ST_AX    = 24'h000400,
    ST_UY    = 24'h000800,
    ST_AY    = 24'h001000,
    ST_VX    = 24'h002000,
    ST_VY    = 24'h004000,
    ST_KWR   = 24'h008000,
    ST_DRD   = 24'h010000,
    ST_DLAT  = 24'h020000,
    ST_PX    = 24'h040000,
    ST_PY    = 24'h080000,
    ST_DWR   = 24'h100000,
    ST_RRD   = 24'h200000,
    ST_RLAT  = 24'h400000,
    ST_RWAIT = 24'h800000
  } state_t;

  localparam body_idx_t LAST_BODY = IDX_W'(BODY_COUNT - 1);

  state_t                state;
  logic                  issued;
  body_idx_t             i_idx;
  body_idx_t             j_idx;
  logic [7:0]            steps_left;
  logic                  phase;
  body_rec_t             rec_i;
  logic                  dx_neg;
  logic                  dy_neg;
  logic [32:0]           mx;
  logic [32:0]           my;
  logic [41:0]           sqx;
  logic [41:0]           r_val;
  logic [32:0]           s_val;
  logic [54:0]           t_val;
  logic [56:0]           u_val;
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic [BODY_COUNT-1:0] sat_flags;

  logic [23:0] time_step;
  logic [30:0] gravity_gain;
  logic [23:0] softening_square;

  body_rec_t out_rec;
  body_idx_t out_body;
  logic      out_sat;
  logic      out_last;

  mem_req_t   mem_req;
  body_rec_t  rd_rec;
  arith_req_t arith_req;
  arith_rsp_t arith_rsp;

  opcode_t    in_opcode;
  body_idx_t  in_body;
  body_rec_t  in_rec;
  logic [7:0] in_steps;
  logic       accept;
  logic       load_ok;
  logic       op_state;

  logic [127:0]            prod;
  logic [ACC_W-1:0]        pair_raw;
  logic                    pair_over;
  logic [ACC_W-1:0]        pair_mag;
  logic [41:0]             r_next;
  logic [32:0]             dxw;
  logic [32:0]             dyw;
  logic signed [31:0]      upd_value;
  logic signed [ACC_W-1:0] upd_delta;
  sat_res_t                upd_res;

  lnb_body_mem u_mem (
    .clk    (clk),
    .rst    (rst),
    .req    (mem_req),
    .rd_rec (rd_rec)
  );

  lnb_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (arith_req),
    .rsp (arith_rsp)
  );

  // input item fields
  assign in_opcode    = opcode_t'(s_tuser);
  assign in_body      = s_tdata[1:0];
  assign in_rec.pos_x = s_tdata[33:2];
  assign in_rec.pos_y = s_tdata[65:34];
  assign in_rec.vel_x = s_tdata[97:66];
  assign in_rec.vel_y = s_tdata[129:98];
  assign in_steps     = s_tdata[137:130];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load_ok  = accept && (in_opcode == OPC_LOAD) && (in_body <= LAST_BODY);

  // output item fields
  assign m_tdata = {6'd0, out_rec.vel_y, out_rec.vel_x, out_rec.pos_y, out_rec.pos_x,
                    out_body};
  assign m_tuser = out_sat;
  assign m_tlast = out_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step        <= 24'd16777;
      gravity_gain     <= 31'd16777216;
      softening_square <= 24'd1678;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_TIME_STEP:    time_step <= cfg_data[23:0];
        CFG_GRAVITY_GAIN: gravity_gain <= cfg_data;
        CFG_SOFTENING:    softening_square <= cfg_data[23:0];
        default:          time_step <= time_step;
      endcase
    end
  end

  // body store port
  always_comb begin
    mem_req.we    = load_ok || (state == ST_KWR) || (state == ST_DWR);
    mem_req.waddr = (state == ST_IDLE) ? in_body : i_idx;
    mem_req.wdata = (state == ST_IDLE) ? in_rec : rec_i;
    mem_req.raddr = (state == ST_PRD) ? j_idx : i_idx;
  end

  // shared unit operands per state
  always_comb begin
    op_state      = 1'b1;
    arith_req.op  = ARITH_MUL;
    arith_req.a   = '0;
    arith_req.b   = '0;
    unique case (state)
      ST_MXX: begin
        arith_req.a = 64'(mx);
        arith_req.b = 64'(mx);
      end
      ST_MYY: begin
        arith_req.a = 64'(my);
        arith_req.b = 64'(my);
      end
      ST_SQRT: begin
        arith_req.op = ARITH_SQRT;
        arith_req.a  = 64'(r_val);
      end
      ST_TDIV: begin
        arith_req.op = ARITH_DIV;
        arith_req.a  = 64'(gravity_gain) << FRACTION_BITS;
        arith_req.b  = 64'(r_val);
      end
      ST_UX: begin
        arith_req.op = ARITH_DIV;
        arith_req.a  = 64'(mx) << FRACTION_BITS;
        arith_req.b  = 64'(s_val);
      end
      ST_UY: begin
        arith_req.op = ARITH_DIV;
        arith_req.a  = 64'(my) << FRACTION_BITS;
        arith_req.b  = 64'(s_val);
      end
      ST_AX, ST_AY: begin
        arith_req.a = 64'(t_val);
        arith_req.b = 64'(u_val);
      end
      ST_VX: begin
        arith_req.a = 64'(mag_acc(acc_x));
        arith_req.b = 64'(time_step);
      end
      ST_VY: begin
        arith_req.a = 64'(mag_acc(acc_y));
        arith_req.b = 64'(time_step);
      end
      ST_PX: begin
        arith_req.a = 64'(mag32(rec_i.vel_x));
        arith_req.b = 64'(time_step);
      end
      ST_PY: begin
        arith_req.a = 64'(mag32(rec_i.vel_y));
        arith_req.b = 64'(time_step);
      end
      default: begin
        op_state = 1'b0;
      end
    endcase
    arith_req.start = op_state && !issued;
  end

  // result post-processing
  always_comb begin
    prod      = arith_rsp.result;
    pair_raw  = prod[FRACTION_BITS +: ACC_W];
    pair_over = (|prod[127:64]) || (pair_raw > PAIR_LIMIT);
    pair_mag  = pair_over ? PAIR_LIMIT : pair_raw;
    r_next    = sqx + prod[FRACTION_BITS +: 42] + 42'(softening_square);
    dxw       = {rd_rec.pos_x[31], rd_rec.pos_x} - {rec_i.pos_x[31], rec_i.pos_x};
    dyw       = {rd_rec.pos_y[31], rd_rec.pos_y} - {rec_i.pos_y[31], rec_i.pos_y};
    unique case (state)
      ST_VX: begin
        upd_value = rec_i.vel_x;
        upd_delta = apply_sign(acc_x[ACC_W-1], prod[FRACTION_BITS + 1 +: ACC_W]);
      end
      ST_VY: begin
        upd_value = rec_i.vel_y;
        upd_delta = apply_sign(acc_y[ACC_W-1], prod[FRACTION_BITS + 1 +: ACC_W]);
      end
      ST_PX: begin
        upd_value = rec_i.pos_x;
        upd_delta = apply_sign(rec_i.vel_x[31], prod[FRACTION_BITS +: ACC_W]);
      end
      default: begin
        upd_value = rec_i.pos_y;
        upd_delta = apply_sign(rec_i.vel_y[31], prod[FRACTION_BITS +: ACC_W]);
      end
    endcase
    upd_res = sat_add(upd_value, upd_delta);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issued     <= 1'b0;
      i_idx      <= '0;
      j_idx      <= '0;
      steps_left <= '0;
      phase      <= 1'b0;
      m_tvalid   <= 1'b0;
      sat_flags  <= '0;
    end else begin
      if (op_state) begin
        if (!issued) begin
          issued <= 1'b1;
        end else if (arith_rsp.done) begin
          issued <= 1'b0;
        end
      end
      unique case (state)
        ST_IDLE: begin
          i_idx <= '0;
          phase <= 1'b0;
          if (load_ok) begin
            sat_flags[in_body] <= 1'b0;
          end
          if (accept && in_opcode == OPC_RUN) begin
            steps_left <= in_steps;
            state      <= (in_steps == 8'd0) ? ST_RRD : ST_KRD;
          end else if (accept && in_opcode == OPC_READ) begin
            state <= ST_RRD;
          end
        end
        // half kick, one body at a time
        ST_KRD: state <= ST_KLAT;
        ST_KLAT: begin
          rec_i <= rd_rec;
          acc_x <= '0;
          acc_y <= '0;
          j_idx <= '0;
          state <= ST_PRD;
        end
        ST_PRD: begin
          if (j_idx == i_idx) begin
            if (j_idx == LAST_BODY) begin
              state <= ST_VX;
            end else begin
              j_idx <= j_idx + IDX_W'(1);
            end
          end else begin
            state <= ST_PLAT;
          end
        end
        ST_PLAT: begin
          dx_neg <= dxw[32];
          dy_neg <= dyw[32];
          mx     <= dxw[32] ? (~dxw + 33'd1) : dxw;
          my     <= dyw[32] ? (~dyw + 33'd1) : dyw;
          state  <= ST_MXX;
        end
        ST_MXX: begin
          if (issued && arith_rsp.done) begin
            sqx   <= prod[FRACTION_BITS +: 42];
            state <= ST_MYY;
          end
        end
        ST_MYY: begin
          if (issued && arith_rsp.done) begin
            r_val <= r_next;
            // zero separation and zero softening: no force
            if (r_next == 42'd0) begin
              if (j_idx == LAST_BODY) begin
                state <= ST_VX;
              end else begin
                j_idx <= j_idx + IDX_W'(1);
                state <= ST_PRD;
              end
            end else begin
              state <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          if (issued && arith_rsp.done) begin
            s_val <= prod[32:0];
            state <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          if (issued && arith_rsp.done) begin
            t_val <= prod[54:0];
            state <= ST_UX;
          end
        end
        ST_UX: begin
          if (issued && arith_rsp.done) begin
            u_val <= prod[56:0];
            state <= ST_AX;
          end
        end
        ST_AX: begin
          if (issued && arith_rsp.done) begin
            acc_x <= acc_x + apply_sign(dx_neg, pair_mag);
            if (pair_over) begin
              sat_flags <= sat_flags | (BODY_COUNT'(1) << i_idx) | (BODY_COUNT'(1) << j_idx);
            end
            state <= ST_UY;
          end
        end
        ST_UY: begin
          if (issued && arith_rsp.done) begin
            u_val <= prod[56:0];
            state <= ST_AY;
          end
        end
        ST_AY: begin
          if (issued && arith_rsp.done) begin
            acc_y <= acc_y + apply_sign(dy_neg, pair_mag);
            if (pair_over) begin
              sat_flags <= sat_flags | (BODY_COUNT'(1) << i_idx) | (BODY_COUNT'(1) << j_idx);
            end
            if (j_idx == LAST_BODY) begin
              state <= ST_VX;
            end else begin
              j_idx <= j_idx + IDX_W'(1);
              state <= ST_PRD;
            end
          end
        end
        ST_VX: begin
          if (issued && arith_rsp.done) begin
            rec_i.vel_x <= upd_res.value;
            if (upd_res.sat) begin
              sat_flags[i_idx] <= 1'b1;
            end
            state <= ST_VY;
          end
        end
        ST_VY: begin
          if (issued && arith_rsp.done) begin
            rec_i.vel_y <= upd_res.value;
            if (upd_res.sat) begin
              sat_flags[i_idx] <= 1'b1;
            end
            state <= ST_KWR;
          end
        end
        ST_KWR: begin
          if (i_idx == LAST_BODY) begin
            i_idx <= '0;
            if (!phase) begin
              state <= ST_DRD;
            end else if (steps_left == 8'd1) begin
              steps_left <= '0;
              state      <= ST_RRD;
            end else begin
              steps_left <= steps_left - 8'd1;
              phase      <= 1'b0;
              state      <= ST_KRD;
            end
          end else begin
            i_idx <= i_idx + IDX_W'(1);
            state <= ST_KRD;
          end
        end
        // drift, one body at a time
        ST_DRD: state <= ST_DLAT;
        ST_DLAT: begin
          rec_i <= rd_rec;
          state <= ST_PX;
        end
        ST_PX: begin
          if (issued && arith_rsp.done) begin
            rec_i.pos_x <= upd_res.value;
            if (upd_res.sat) begin
              sat_flags[i_idx] <= 1'b1;
            end
            state <= ST_PY;
          end
        end
        ST_PY: begin
          if (issued && arith_rsp.done) begin
            rec_i.pos_y <= upd_res.value;
            if (upd_res.sat) begin
              sat_flags[i_idx] <= 1'b1;
            end
            state <= ST_DWR;
          end
        end
        ST_DWR: begin
          if (i_idx == LAST_BODY) begin
            i_idx <= '0;
            phase <= 1'b1;
            state <= ST_KRD;
          end else begin
            i_idx <= i_idx + IDX_W'(1);
            state <= ST_DRD;
          end
        end
        // report, one item per body
        ST_RRD: state <= ST_RLAT;
        ST_RLAT: begin
          out_rec          <= rd_rec;
          out_body         <= i_idx;
          out_sat          <= sat_flags[i_idx];
          out_last         <= (i_idx == LAST_BODY);
          sat_flags[i_idx] <= 1'b0;
          m_tvalid         <= 1'b1;
          state            <= ST_RWAIT;
        end
        ST_RWAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (i_idx == LAST_BODY) begin
              i_idx <= '0;
              state <= ST_IDLE;
            end else begin
              i_idx <= i_idx + IDX_W'(1);
              state <= ST_RRD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_in_wait: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (state == ST_RWAIT))
    else $error("report item valid outside the wait state");

  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    arith_rsp.done |-> issued)
    else $error("shared unit finished without a pending operation");

  a_last_body: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (out_body == LAST_BODY))
    else $error("last flag on a body other than the final one");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RWAIT && !m_tready) |=> (m_tvalid && state == ST_RWAIT))
    else $error("stalled report item dropped");
`endif

endmodule

// ===== rtl/lnb_arith.sv =====
`timescale 1ns / 1ps
module lnb_arith (
  input  logic               clk,
  input  logic               rst,
  input  lnb_pkg::arith_req_t req,
  output lnb_pkg::arith_rsp_t rsp
);
  import lnb_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  arith_op_t        op;
  logic [63:0]      opb;
  logic [67:0]      hi;
  logic [127:0]     lo;
  logic [63:0]      root;

  logic [67:0]  hi_next;
  logic [127:0] lo_next;
  logic [63:0]  root_next;
  logic [64:0]  mul_sum;
  logic [64:0]  div_sh;
  logic [64:0]  div_sub;
  logic [67:0]  sq_sh;
  logic [67:0]  sq_trial;
  logic         ge;

  // one iteration of the selected operation
  always_comb begin
    hi_next   = hi;
    lo_next   = lo;
    root_next = root;
    mul_sum   = hi[64:0] + (lo[0] ? {1'b0, opb} : 65'd0);
    div_sh    = {hi[63:0], lo[63]};
    div_sub   = div_sh - {1'b0, opb};
    sq_sh     = {hi[65:0], lo[127:126]};
    sq_trial  = {2'b00, root, 2'b01};
    ge        = 1'b0;
    case (op)
      ARITH_MUL: begin
        hi_next = 68'(mul_sum[64:1]);
        lo_next = {64'd0, mul_sum[0], lo[63:1]};
      end
      ARITH_DIV: begin
        ge      = div_sh >= {1'b0, opb};
        hi_next = 68'(ge ? div_sub[63:0] : div_sh[63:0]);
        lo_next = {64'd0, lo[62:0], ge};
      end
      ARITH_SQRT: begin
        ge        = sq_sh >= sq_trial;
        hi_next   = ge ? (sq_sh - sq_trial) : sq_sh;
        lo_next   = {lo[125:0], 2'b00};
        root_next = {root[62:0], ge};
      end
      default: begin
        hi_next = hi;
      end
    endcase
  end

  // control of the iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(ITER_COUNT - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      op   <= req.op;
      opb  <= req.b;
      hi   <= '0;
      root <= '0;
      if (req.op == ARITH_SQRT) begin
        lo <= 128'(req.a) << FRACTION_BITS;
      end else begin
        lo <= {64'd0, req.a};
      end
    end else if (busy) begin
      hi   <= hi_next;
      lo   <= lo_next;
      root <= root_next;
    end
  end

  // result selection
  always_comb begin
    rsp.done = done;
    case (op)
      ARITH_MUL:  rsp.result = {hi[63:0], lo[63:0]};
      ARITH_DIV:  rsp.result = {64'd0, lo[63:0]};
      ARITH_SQRT: rsp.result = {64'd0, root};
      default:    rsp.result = '0;
    endcase
  end

endmodule

// ===== rtl/lnb_body_mem.sv =====
`timescale 1ns / 1ps
module lnb_body_mem (
  input  logic               clk,
  input  logic               rst,
  input  lnb_pkg::mem_req_t  req,
  output lnb_pkg::body_rec_t rd_rec
);
  import lnb_pkg::*;

  body_rec_t             mem [BODY_COUNT];
  logic [BODY_COUNT-1:0] valid;
  body_rec_t             rd_data;
  logic                  rd_valid;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

  // entries read as zero until written after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      rd_valid <= valid[req.raddr];
    end
  end

  assign rd_rec = rd_valid ? rd_data : '0;

endmodule

// ===== verif/tb_leapfrog_nbody_gravity_step_unit.sv =====
`timescale 1ns / 1ps
module tb_leapfrog_nbody_gravity_step_unit;
  import lnb_pkg::*;

  localparam int NB          = 3;
  localparam int FB          = 24;
  localparam int STALL_LIMIT = 3000000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // body_index, load_pos_x, load_pos_y, load_vel_x, load_vel_y, step_count
  logic [143:0] s_tdata;
  // opcode
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  // out_body, out_pos_x, out_pos_y, out_vel_x, out_vel_y
  logic [135:0] m_tdata;
  // saturated
  logic [0:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [30:0]  cfg_data;

  leapfrog_nbody_gravity_step_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  typedef struct {
    logic [1:0]         body;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               sat;
    logic               last;
  } body_report_t;

  typedef struct {
    opcode_t     op;
    logic [1:0]  body;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [7:0]  steps;
    bit          zero_state;
  } cmd_row_t;

  // body state and registers as the predictor sees them
  logic signed [31:0] st_px[NB];
  logic signed [31:0] st_py[NB];
  logic signed [31:0] st_vx[NB];
  logic signed [31:0] st_vy[NB];
  bit                 st_sat[NB];
  logic [63:0]        dt_reg;
  logic [63:0]        gain_reg;
  logic [63:0]        eps_reg;

  body_report_t reports_due[$];
  cmd_row_t     cmd_tab[$];
  int           errors = 0;
  bit           calm;
  bit           hold_req;
  int           quiet_cycles;

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // floor(sqrt(r * 2^FB)), two bits per round
  function automatic logic [63:0] root_scaled(logic [63:0] r);
    logic [127:0] v, rem, trial;
    logic [63:0]  root;
    v = {64'd0, r} << FB;
    rem = '0;
    root = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 2) | ((v >> (2 * k)) & 128'd3);
      trial = ({64'd0, root} << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // one component of a pair acceleration, clamped to the pair limit
  function automatic logic [63:0] pair_component(logic [63:0] t, logic [63:0] m,
                                                 logic [63:0] s, ref bit sat);
    logic [63:0]  u;
    logic [127:0] prod;
    logic [127:0] a;
    u = (m << FB) / s;
    prod = {64'd0, t} * {64'd0, u};
    if (prod[127:64] != 0) begin
      sat = 1'b1;
      return 64'd1 << 35;
    end
    a = prod >> FB;
    if (a > (128'd1 << 35)) begin
      sat = 1'b1;
      return 64'd1 << 35;
    end
    return a[63:0];
  endfunction

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // magnitude times time step, shifted down, sign restored
  function automatic longint dt_scaled(longint v, int sh);
    logic [127:0] p;
    p = ({64'd0, mag64(v)} * {64'd0, dt_reg}) >> sh;
    return v < 0 ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic signed [31:0] clamp_add(logic signed [31:0] a, longint d, int b);
    longint s;
    s = longint'(a) + d;
    if (s > 64'sd2147483647) begin
      s = 64'sd2147483647;
      st_sat[b] = 1'b1;
    end
    if (s < -64'sd2147483648) begin
      s = -64'sd2147483648;
      st_sat[b] = 1'b1;
    end
    return s[31:0];
  endfunction

  // pairwise softened gravity, then a half-step velocity update
  task automatic half_kick();
    longint ax[NB], ay[NB];
    longint dx, dy, cx, cy;
    logic [63:0] mx, my, r, s, t, a;
    bit sat;
    for (int i = 0; i < NB; i++) begin
      ax[i] = 0;
      ay[i] = 0;
    end
    for (int i = 0; i < NB; i++) begin
      for (int j = i + 1; j < NB; j++) begin
        dx = longint'(st_px[j]) - longint'(st_px[i]);
        dy = longint'(st_py[j]) - longint'(st_py[i]);
        mx = mag64(dx);
        my = mag64(dy);
        r = ((mx * mx) >> FB) + ((my * my) >> FB) + eps_reg;
        if (r != 0) begin
          sat = 1'b0;
          s = root_scaled(r);
          t = (gain_reg << FB) / r;
          a = pair_component(t, mx, s, sat);
          cx = dx < 0 ? -longint'(a) : longint'(a);
          a = pair_component(t, my, s, sat);
          cy = dy < 0 ? -longint'(a) : longint'(a);
          ax[i] += cx;
          ay[i] += cy;
          ax[j] -= cx;
          ay[j] -= cy;
          if (sat) begin
            st_sat[i] = 1'b1;
            st_sat[j] = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < NB; i++) begin
      st_vx[i] = clamp_add(st_vx[i], dt_scaled(ax[i], FB + 1), i);
      st_vy[i] = clamp_add(st_vy[i], dt_scaled(ay[i], FB + 1), i);
    end
  endtask

  task automatic leapfrog_step();
    half_kick();
    for (int i = 0; i < NB; i++) begin
      st_px[i] = clamp_add(st_px[i], dt_scaled(longint'(st_vx[i]), FB), i);
      st_py[i] = clamp_add(st_py[i], dt_scaled(longint'(st_vy[i]), FB), i);
    end
    half_kick();
  endtask

  // queue one report per body; zero_state rows expect an all-zero body set
  task automatic queue_report(bit zero_state);
    body_report_t e;
    for (int i = 0; i < NB; i++) begin
      e.body = 2'(i);
      e.px = zero_state ? 32'sd0 : st_px[i];
      e.py = zero_state ? 32'sd0 : st_py[i];
      e.vx = zero_state ? 32'sd0 : st_vx[i];
      e.vy = zero_state ? 32'sd0 : st_vy[i];
      e.sat = zero_state ? 1'b0 : st_sat[i];
      e.last = (i == NB - 1);
      reports_due.push_back(e);
      st_sat[i] = 1'b0;
    end
  endtask

  task automatic predict_cmd(cmd_row_t c);
    case (c.op)
      OPC_LOAD: begin
        if (c.body < NB) begin
          st_px[c.body] = c.px;
          st_py[c.body] = c.py;
          st_vx[c.body] = c.vx;
          st_vy[c.body] = c.vy;
          st_sat[c.body] = 1'b0;
        end
      end
      OPC_RUN: begin
        for (int k = 0; k < c.steps; k++) leapfrog_step();
        queue_report(c.zero_state);
      end
      OPC_READ: queue_report(c.zero_state);
      default: ;
    endcase
  endtask

  // offer one item and wait for it to be taken
  task automatic offer(cmd_row_t c);
    s_tuser <= c.op;
    s_tdata <= {6'd0, c.steps, c.vy, c.vx, c.py, c.px, c.body};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_cmd(c);
  endtask

  task automatic pause_sender(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 18));
  endtask

  // idle until every report has come, plus the time of a trailing load
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_t idx, logic [30:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TIME_STEP:    dt_reg = {40'd0, v[23:0]};
      CFG_GRAVITY_GAIN: gain_reg = {33'd0, v};
      CFG_SOFTENING:    eps_reg = {40'd0, v[23:0]};
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  function automatic cmd_row_t row(opcode_t op, logic [1:0] b, logic [31:0] px,
                                   logic [31:0] py, logic [31:0] vx, logic [31:0] vy,
                                   logic [7:0] n, bit z);
    cmd_row_t c;
    c.op = op;
    c.body = b;
    c.px = px;
    c.py = py;
    c.vx = vx;
    c.vy = vy;
    c.steps = n;
    c.zero_state = z;
    return c;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom()) >>> $urandom_range(6, 12);
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          default: return 32'hffffffff;
        endcase
      end
      default: return $signed($urandom()) >>> $urandom_range(0, 5);
    endcase
  endfunction

  function automatic cmd_row_t rand_cmd();
    int pick;
    cmd_row_t c;
    pick = $urandom_range(0, 99);
    c = row(OPC_READ, 2'($urandom()), rand_value(), rand_value(), rand_value(),
            rand_value(), 8'd1, 1'b0);
    if (pick < 45) begin
      c.op = OPC_LOAD;
      c.body = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    end else if (pick < 55) begin
      c.op = OPC_NONE;
    end else if (pick >= 82) begin
      c.op = OPC_RUN;
      case ($urandom_range(0, 9))
        0: c.steps = 8'd0;
        1: c.steps = 8'($urandom_range(2, 3));
        default: c.steps = 8'd1;
      endcase
    end
    return c;
  endfunction

  // report checker
  always @(posedge clk) begin
    body_report_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (reports_due.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        e = reports_due.pop_front();
        if (m_tdata[1:0] !== e.body) report_mismatch("out_body", m_tdata[1:0], e.body);
        if ($signed(m_tdata[33:2]) !== e.px)
          report_mismatch("out_pos_x", $signed(m_tdata[33:2]), e.px);
        if ($signed(m_tdata[65:34]) !== e.py)
          report_mismatch("out_pos_y", $signed(m_tdata[65:34]), e.py);
        if ($signed(m_tdata[97:66]) !== e.vx)
          report_mismatch("out_vel_x", $signed(m_tdata[97:66]), e.vx);
        if ($signed(m_tdata[129:98]) !== e.vy)
          report_mismatch("out_vel_y", $signed(m_tdata[129:98]), e.vy);
        if (m_tuser[0] !== e.sat) report_mismatch("saturated", m_tuser[0], e.sat);
        if (m_tlast !== e.last) report_mismatch("last", m_tlast, e.last);
      end
    end
  end

  // receiver: random stalls, one long hold on request
  initial begin
    bit held;
    held = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OPC_LOAD;
    cfg_we = 1'b0;
    cfg_addr = CFG_TIME_STEP;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    dt_reg = 64'd16777;
    gain_reg = 64'd16777216;
    eps_reg = 64'd1678;
    for (int i = 0; i < NB; i++) begin
      st_px[i] = '0;
      st_py[i] = '0;
      st_vx[i] = '0;
      st_vy[i] = '0;
      st_sat[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset register values
    cmd_tab.push_back(row(OPC_READ, 2'd0, 0, 0, 0, 0, 8'd0, 1'b1));
    cmd_tab.push_back(row(OPC_RUN, 2'd0, 0, 0, 0, 0, 8'd0, 1'b1));
    cmd_tab.push_back(row(OPC_LOAD, 2'd0, 32'h01000000, 0, 0, 32'h00800000, 8'd0, 1'b0));
    cmd_tab.push_back(row(OPC_LOAD, 2'd1, 32'hff000000, 32'h00400000, 32'hffc00000, 0,
                          8'd0, 1'b0));
    // drift carries these straight into the clamp
    cmd_tab.push_back(row(OPC_LOAD, 2'd2, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                          8'd0, 1'b0));
    // body index out of range, ignored
    cmd_tab.push_back(row(OPC_LOAD, 2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                          32'hffffffff, 8'hff, 1'b0));
    cmd_tab.push_back(row(OPC_NONE, 2'd1, 32'h12345678, 32'h9abcdef0, 32'h0, 32'h1, 8'd7,
                          1'b0));
    cmd_tab.push_back(row(OPC_RUN, 2'd0, 0, 0, 0, 0, 8'd1, 1'b0));
    cmd_tab.push_back(row(OPC_READ, 2'd0, 0, 0, 0, 0, 8'd0, 1'b0));
    cmd_tab.push_back(row(OPC_LOAD, 2'd2, 32'h01000000, 0, 0, 0, 8'd0, 1'b0));
    cmd_tab.push_back(row(OPC_RUN, 2'd0, 0, 0, 0, 0, 8'd2, 1'b0));
    cmd_tab.push_back(row(OPC_READ, 2'd0, 0, 0, 0, 0, 8'd0, 1'b0));
    foreach (cmd_tab[i]) begin
      offer(cmd_tab[i]);
      maybe_gap();
    end
    drain();

    // directed, extreme registers: pair clamp, zero separation, longest run
    set_reg(CFG_SOFTENING, 31'd0);
    set_reg(CFG_GRAVITY_GAIN, 31'h7fffffff);
    set_reg(CFG_TIME_STEP, 31'h00ffffff);
    set_reg(CFG_UNUSED, 31'h55555555);
    cmd_tab.delete();
    cmd_tab.push_back(row(OPC_LOAD, 2'd0, 0, 0, 0, 0, 8'd0, 1'b0));
    cmd_tab.push_back(row(OPC_LOAD, 2'd1, 32'h00001000, 32'hfffff000, 0, 0, 8'd0, 1'b0));
    cmd_tab.push_back(row(OPC_LOAD, 2'd2, 0, 0, 32'h00000010, 32'hfffffff0, 8'd0, 1'b0));
    cmd_tab.push_back(row(OPC_RUN, 2'd0, 0, 0, 0, 0, 8'd1, 1'b0));
    cmd_tab.push_back(row(OPC_LOAD, 2'd0, 32'h00000100, 32'h00000100, 0, 0, 8'd0, 1'b0));
    cmd_tab.push_back(row(OPC_LOAD, 2'd1, 32'h00000100, 32'h00000100, 0, 0, 8'd0, 1'b0));
    cmd_tab.push_back(row(OPC_LOAD, 2'd2, 32'h00000100, 32'h00000100, 0, 0, 8'd0, 1'b0));
    cmd_tab.push_back(row(OPC_RUN, 2'd0, 0, 0, 0, 0, 8'd255, 1'b0));
    cmd_tab.push_back(row(OPC_READ, 2'd0, 0, 0, 0, 0, 8'd0, 1'b0));
    foreach (cmd_tab[i]) begin
      offer(cmd_tab[i]);
      maybe_gap();
    end
    drain();

    // random phases under several register settings
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          set_reg(CFG_TIME_STEP, 31'd16777);
          set_reg(CFG_GRAVITY_GAIN, 31'd16777216);
          set_reg(CFG_SOFTENING, 31'd1678);
        end
        1: begin
          set_reg(CFG_TIME_STEP, 31'd0);
          set_reg(CFG_GRAVITY_GAIN, 31'd0);
          set_reg(CFG_SOFTENING, 31'h00ffffff);
        end
        default: begin
          set_reg(CFG_TIME_STEP, 31'($urandom_range(0, 32'h00ffffff)));
          set_reg(CFG_GRAVITY_GAIN, 31'($urandom()));
          set_reg(CFG_SOFTENING, 31'($urandom_range(0, 32'h00ffffff)));
        end
      endcase
      if (ph == 0) begin
        // receiver holds off while reads keep coming
        hold_req = 1'b1;
        repeat (6) offer(row(OPC_READ, 2'd0, 0, 0, 0, 0, 8'd0, 1'b0));
      end
      for (int n = 0; n < 100; n++) begin
        if (ph == 0 && n == 50) drain();
        if (ph == 2 && n == 70) calm = 1'b1;
        offer(rand_cmd());
        maybe_gap();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
